/* rtl/core/fiber_bending_force_stencil_defines.svh */
// Assertion macros for the fiber bending force stencil.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef FIBER_BENDING_FORCE_STENCIL_DEFINES_SVH
`define FIBER_BENDING_FORCE_STENCIL_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define FBFS_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define FBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/fbfs_pkg.sv */
// Shared types, constants and saturation helper for the fiber bending force stencil.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fbfs_pkg;

	localparam int DIMENSIONS_DEF  = 3;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	localparam logic [ADDR_W-3:0] REG_RIGIDITY = 1'b0;

	typedef enum logic [1:0] {
		KIND_HOLD,
		KIND_SHORT,
		KIND_STEP,
		KIND_FLUSH
	} item_kind_t;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		item_kind_t kind;
		logic       has_prev;
		logic       sd_clip;
		vec3_t      sd;
		vec3_t      force_in;
	} entry_t;

	// Returns {clip, value}: the value clipped to the signed 32-bit range.
	function automatic logic [32:0] sat32(input logic signed [64:0] v);
		logic [32:0] r;
		if (v > 65'sd2147483647) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (v < -65'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/core/fbfs_front.sv */
// Front end: accepts points, keeps the coordinate window and classifies each request.
// Forms the saturated second difference of the coordinates. Depends on fbfs_pkg.
`timescale 1ns / 1ps

module fbfs_front import fbfs_pkg::*; #(
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic               last_point,
	input  logic               q_full,
	output logic               push,
	output entry_t             push_entry
);

	vec3_t      cw0_q;
	vec3_t      cw1_q;
	logic [1:0] seen_q;
	vec3_t      x;
	vec3_t      y;

	assign x = {coord_z, coord_y, coord_x};
	assign y = {force_z, force_y, force_x};

	assign pt_stall = q_full;
	assign push     = pt_valid && !q_full;

	always_comb begin
		logic signed [34:0] sd_wide;
		logic [32:0]        sat;
		push_entry = '0;
		for (int d = 0; d < 3; d++) begin
			sd_wide = 35'(signed'(cw0_q[d])) - (35'(signed'(cw1_q[d])) <<< 1)
				+ 35'(signed'(x[d]));
			sat = sat32(65'(sd_wide));
			if (d < DIMENSIONS) begin
				push_entry.sd[d]       = sat[31:0];
				push_entry.sd_clip     = push_entry.sd_clip | sat[32];
				push_entry.force_in[d] = y[d];
			end
		end
		push_entry.has_prev = (seen_q == 2'd1);
		if (!seen_q[1]) begin
			push_entry.kind = last_point ? KIND_SHORT : KIND_HOLD;
		end else begin
			push_entry.kind = last_point ? KIND_FLUSH : KIND_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
		end else if (push) begin
			if (last_point) begin
				seen_q <= 2'd0;
			end else if (seen_q != 2'd3) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cw0_q <= cw1_q;
			cw1_q <= x;
		end
	end

endmodule

/* rtl/core/fbfs_queue.sv */
// Short request queue between the front end and the back end.
// First in, first out, with a registered fill count. Depends on fbfs_pkg.
`timescale 1ns / 1ps

module fbfs_queue import fbfs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   q_valid,
	output logic   q_full,
	output entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* rtl/core/fbfs_back.sv */
// Back end: multiplies by the rigidity, forms the bending forces and issues results.
// Holds the pending forces and bend history. Depends on fbfs_pkg and the defines header.
`timescale 1ns / 1ps
`include "fiber_bending_force_stencil_defines.svh"

module fbfs_back import fbfs_pkg::*; #(
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        rigidity,
	input  logic               q_valid,
	input  entry_t             q_entry,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] out_force_x,
	output logic signed [31:0] out_force_y,
	output logic signed [31:0] out_force_z,
	output logic               saturated,
	output logic               last_result
);

	logic               valid_s1;
	entry_t             ent_s1;
	logic signed [64:0] prod_s1 [3];
	logic               valid_s2;
	entry_t             ent_s2;
	vec3_t              f_s2;
	logic               fclip_s2;

	vec3_t      pf0_q;
	vec3_t      pf1_q;
	vec3_t      bh0_q;
	vec3_t      bh1_q;
	logic       bc0_q;
	logic       bc1_q;
	logic [1:0] idx_q;

	logic       res_valid_q;
	vec3_t      res_q;
	logic       sat_q;
	logic       last_q;

	logic       s1_ready;
	logic       s2_ready;
	logic       s2_done;
	logic       out_free;
	logic       out_load;
	logic [1:0] n_res;
	vec3_t      f_next;
	logic       fclip_next;
	vec3_t      res_next;
	logic       sat_next;
	logic       last_next;

	assign s2_ready = !valid_s2 || s2_done;
	assign s1_ready = !valid_s1 || s2_ready;
	assign pop      = q_valid && s1_ready;

	always_comb begin
		logic [32:0] sat;
		f_next     = '0;
		fclip_next = ent_s1.sd_clip;
		for (int d = 0; d < 3; d++) begin
			sat = sat32(prod_s1[d] >>> 16);
			if (d < DIMENSIONS) begin
				f_next[d]  = sat[31:0];
				fclip_next = fclip_next | sat[32];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= q_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1 <= q_entry;
			for (int d = 0; d < 3; d++) begin
				prod_s1[d] <= 65'(signed'({1'b0, rigidity})) * 65'(signed'(q_entry.sd[d]));
			end
		end
		if (s2_ready && valid_s1) begin
			ent_s2   <= ent_s1;
			f_s2     <= f_next;
			fclip_s2 <= fclip_next;
		end
	end

	always_comb begin
		case (ent_s2.kind)
			KIND_HOLD:  n_res = 2'd0;
			KIND_SHORT: n_res = ent_s2.has_prev ? 2'd2 : 2'd1;
			KIND_STEP:  n_res = 2'd1;
			KIND_FLUSH: n_res = 2'd3;
			default:    n_res = 2'd0;
		endcase
	end

	assign out_free = !res_valid_q || !res_stall;
	assign out_load = valid_s2 && (n_res != 2'd0) && out_free;
	assign s2_done  = valid_s2 && ((n_res == 2'd0) || (out_load && (idx_q == n_res - 2'd1)));

	always_comb begin
		vec3_t              ta;
		vec3_t              tb;
		vec3_t              tc;
		vec3_t              td;
		logic               base_clip;
		logic signed [34:0] sum;
		logic [32:0]        sat;
		ta        = '0;
		tb        = '0;
		tc        = '0;
		td        = '0;
		base_clip = 1'b0;
		last_next = 1'b0;
		case (ent_s2.kind)
			KIND_SHORT: begin
				if (ent_s2.has_prev && (idx_q == 2'd0)) begin
					ta = pf1_q;
				end else begin
					ta        = ent_s2.force_in;
					last_next = 1'b1;
				end
			end
			KIND_STEP, KIND_FLUSH: begin
				case (idx_q)
					2'd0: begin
						ta        = pf0_q;
						tb        = f_s2;
						tc        = bh0_q;
						td        = bh1_q;
						base_clip = fclip_s2 | bc0_q | bc1_q;
					end
					2'd1: begin
						ta        = pf1_q;
						tc        = f_s2;
						td        = bh0_q;
						base_clip = fclip_s2 | bc0_q;
					end
					default: begin
						ta        = ent_s2.force_in;
						tb        = f_s2;
						base_clip = fclip_s2;
						last_next = 1'b1;
					end
				endcase
			end
			default: begin
				ta = '0;
			end
		endcase
		res_next = '0;
		sat_next = base_clip;
		for (int d = 0; d < 3; d++) begin
			sum = 35'(signed'(ta[d])) - 35'(signed'(tb[d]))
				+ (35'(signed'(tc[d])) <<< 1) - 35'(signed'(td[d]));
			sat = sat32(65'(sum));
			if (d < DIMENSIONS) begin
				res_next[d] = sat[31:0];
				sat_next    = sat_next | sat[32];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			res_valid_q <= 1'b0;
			bh0_q       <= '0;
			bh1_q       <= '0;
			bc0_q       <= 1'b0;
			bc1_q       <= 1'b0;
		end else begin
			if (s2_done) begin
				idx_q <= 2'd0;
			end else if (out_load) begin
				idx_q <= idx_q + 2'd1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (s2_done) begin
				case (ent_s2.kind)
					KIND_STEP: begin
						bh1_q <= bh0_q;
						bh0_q <= f_s2;
						bc1_q <= bc0_q;
						bc0_q <= fclip_s2;
					end
					KIND_SHORT, KIND_FLUSH: begin
						bh0_q <= '0;
						bh1_q <= '0;
						bc0_q <= 1'b0;
						bc1_q <= 1'b0;
					end
					default: begin
						bc0_q <= bc0_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done && (ent_s2.kind == KIND_HOLD || ent_s2.kind == KIND_STEP)) begin
			pf0_q <= pf1_q;
			pf1_q <= ent_s2.force_in;
		end
		if (out_load) begin
			res_q  <= res_next;
			sat_q  <= sat_next;
			last_q <= last_next;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_force_x = signed'(res_q[0]);
	assign out_force_y = signed'(res_q[1]);
	assign out_force_z = signed'(res_q[2]);
	assign saturated   = sat_q;
	assign last_result = last_q;

	`FBFS_ASSERT(a_idx_range, clk, arst_n, valid_s2 && (n_res != 2'd0), idx_q < n_res, "result index beyond the request's result count")
	`FBFS_ASSERT(a_idx_idle, clk, arst_n, !valid_s2, idx_q == 2'd0, "result index not at zero without a request")
	`FBFS_ASSERT_NEXT(a_fiber_clear, clk, arst_n, s2_done && (ent_s2.kind == KIND_SHORT || ent_s2.kind == KIND_FLUSH), !bc0_q && !bc1_q && (bh0_q == '0) && (bh1_q == '0), "bend history not cleared at the end of a fiber")
	`FBFS_ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, res_valid_q, "loaded result not presented")

endmodule

/* rtl/core/fiber_bending_force_stencil.sv */
// Top level of the fiber bending force stencil: configuration register and channel wiring.
// Instantiates fbfs_front, fbfs_queue and fbfs_back; depends on fbfs_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   points   | pt_valid / pt_stall | coord_x/y/z, force_x/y/z, last_point
//   results  | res_valid/res_stall | out_force_x/y/z, saturated, last_result
//   config   | APB psel/penable    | paddr, pwdata, prdata (rigidity at 0)
//
// One point is taken per cycle while the request queue has room; a result is registered
// in turn in the queue, the multiply stage, the force stage and the output register.
// The last point of a fiber issues up to three results, one per cycle while res_stall
// is low, from the single result port; a point that is only held still passes
// through the back end without issuing a result.
// Reset clears the fill count, the pipeline valids and the rigidity to zero.
// A stalled result holds the output register; the queue then fills and pt_stall rises.
`timescale 1ns / 1ps

module fiber_bending_force_stencil import fbfs_pkg::*; #(
	parameter int DIMENSIONS  = DIMENSIONS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic               last_point,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] out_force_x,
	output logic signed [31:0] out_force_y,
	output logic signed [31:0] out_force_z,
	output logic               saturated,
	output logic               last_result
);

	logic [DATA_W-1:0] rigidity_q;
	logic              hit_rigidity;
	logic              push;
	entry_t            push_entry;
	logic              pop;
	logic              q_valid;
	logic              q_full;
	entry_t            head;

	assign pready       = 1'b1;
	assign hit_rigidity = (paddr[ADDR_W-1:2] == REG_RIGIDITY);
	assign prdata       = hit_rigidity ? rigidity_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rigidity_q <= '0;
		end else if (psel && penable && pwrite && pready && hit_rigidity) begin
			rigidity_q <= pwdata;
		end
	end

	fbfs_front #(
		.DIMENSIONS(DIMENSIONS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_stall   (pt_stall),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.force_x    (force_x),
		.force_y    (force_y),
		.force_z    (force_z),
		.last_point (last_point),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	fbfs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_full     (q_full),
		.head       (head)
	);

	fbfs_back #(
		.DIMENSIONS(DIMENSIONS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rigidity    (rigidity_q),
		.q_valid     (q_valid),
		.q_entry     (head),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_force_x (out_force_x),
		.out_force_y (out_force_y),
		.out_force_z (out_force_z),
		.saturated   (saturated),
		.last_result (last_result)
	);

endmodule

/* dv/fbfs_bend_checker.sv */
// Scoreboard for the fiber bending force stencil: predicts the updated forces of every point
// request and compares them with the results. Depends on fbfs_pkg for types and widths.
`timescale 1ns / 1ps

module fbfs_bend_checker import fbfs_pkg::*; #(
	parameter int DIMS = DIMENSIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	input  logic               pready,
	input  logic               pt_valid,
	input  logic               pt_stall,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic               last_point,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic signed [31:0] out_force_x,
	input  logic signed [31:0] out_force_y,
	input  logic signed [31:0] out_force_z,
	input  logic               saturated,
	input  logic               last_result,
	output int                 mismatch_count,
	output int                 pending
);

	localparam logic [ADDR_W-1:0] RIGIDITY_ADDR = {REG_RIGIDITY, 2'b00};

	typedef struct packed {
		vec3_t fvec;
		logic  sat;
		logic  last;
	} bend_result_t;

	bend_result_t expected_forces[$];

	logic [31:0] gain;
	vec3_t       coord_old, coord_new, force_old, force_new, bend_new, bend_prev;
	bit          clip_new, clip_prev;
	int          fiber_fill;

	function automatic longint sx(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [31:0] clip32(input longint v, inout bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic push_result(input vec3_t v, input bit sat, input bit last);
		bend_result_t e;
		int d;
		for (d = 0; d < 3; d++) begin
			e.fvec[d] = (d < DIMS) ? v[d] : 32'h0;
		end
		e.sat  = sat;
		e.last = last;
		expected_forces.push_back(e);
	endtask

	task automatic clear_fiber();
		coord_old  = '0;
		coord_new  = '0;
		force_old  = '0;
		force_new  = '0;
		bend_new   = '0;
		bend_prev  = '0;
		clip_new   = 1'b0;
		clip_prev  = 1'b0;
		fiber_fill = 0;
	endtask

	task automatic predict_point(input vec3_t x, input vec3_t y, input bit last);
		vec3_t  f, r;
		bit     fclip, c;
		longint sd;
		logic [31:0] s;
		int d;
		if (fiber_fill < 2) begin
			if (last) begin
				if (fiber_fill == 1) begin
					push_result(force_new, 1'b0, 1'b0);
				end
				push_result(y, 1'b0, 1'b1);
				clear_fiber();
				return;
			end
			coord_old  = coord_new;
			force_old  = force_new;
			coord_new  = x;
			force_new  = y;
			fiber_fill = fiber_fill + 1;
			return;
		end
		fclip = 1'b0;
		for (d = 0; d < 3; d++) begin
			f[d] = 32'h0;
			if (d < DIMS) begin
				sd   = sx(coord_old[d]) - 2 * sx(coord_new[d]) + sx(x[d]);
				s    = clip32(sd, fclip);
				f[d] = clip32((longint'(gain) * sx(s)) >>> 16, fclip);
			end
		end
		c = fclip || clip_new || clip_prev;
		for (d = 0; d < 3; d++) begin
			r[d] = 32'h0;
			if (d < DIMS) begin
				r[d] = clip32(sx(force_old[d]) - sx(f[d]) + 2 * sx(bend_new[d])
					- sx(bend_prev[d]), c);
			end
		end
		push_result(r, c, 1'b0);
		if (last) begin
			c = fclip || clip_new;
			for (d = 0; d < 3; d++) begin
				r[d] = 32'h0;
				if (d < DIMS) begin
					r[d] = clip32(sx(force_new[d]) + 2 * sx(f[d]) - sx(bend_new[d]), c);
				end
			end
			push_result(r, c, 1'b0);
			c = fclip;
			for (d = 0; d < 3; d++) begin
				r[d] = 32'h0;
				if (d < DIMS) begin
					r[d] = clip32(sx(y[d]) - sx(f[d]), c);
				end
			end
			push_result(r, c, 1'b1);
			clear_fiber();
			return;
		end
		coord_old  = coord_new;
		force_old  = force_new;
		coord_new  = x;
		force_new  = y;
		bend_prev  = bend_new;
		bend_new   = f;
		clip_prev  = clip_new;
		clip_new   = fclip;
		fiber_fill = 3;
	endtask

	task automatic check_result(input bend_result_t got);
		bend_result_t e;
		if (expected_forces.size() == 0) begin
			if (mismatch_count < 10) begin
				$display("unexpected result: x=%h y=%h z=%h sat=%b last=%b",
					got.fvec[0], got.fvec[1], got.fvec[2], got.sat, got.last);
			end
			mismatch_count = mismatch_count + 1;
			return;
		end
		e = expected_forces.pop_front();
		if (got.fvec[0] !== e.fvec[0] || got.fvec[1] !== e.fvec[1]
				|| got.fvec[2] !== e.fvec[2] || got.sat !== e.sat
				|| got.last !== e.last) begin
			if (mismatch_count < 10) begin
				$display("mismatch: expected x=%h y=%h z=%h sat=%b last=%b", e.fvec[0],
					e.fvec[1], e.fvec[2], e.sat, e.last);
				$display("          actual   x=%h y=%h z=%h sat=%b last=%b",
					got.fvec[0], got.fvec[1], got.fvec[2], got.sat, got.last);
			end
			mismatch_count = mismatch_count + 1;
		end
	endtask

	initial begin
		mismatch_count = 0;
		pending        = 0;
		gain           = '0;
		clear_fiber();
	end

	always @(posedge clk or negedge arst_n) begin
		bend_result_t got;
		if (!arst_n) begin
			gain = '0;
			clear_fiber();
			expected_forces.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == RIGIDITY_ADDR) begin
				gain = pwdata;
			end
			if (pt_valid && !pt_stall) begin
				predict_point({coord_z, coord_y, coord_x}, {force_z, force_y, force_x},
					last_point);
			end
			if (res_valid && !res_stall) begin
				got.fvec = {out_force_z, out_force_y, out_force_x};
				got.sat  = saturated;
				got.last = last_result;
				check_result(got);
			end
		end
		pending = expected_forces.size();
	end

endmodule

/* dv/tb_top.sv */
// Top of the fiber bending force stencil testbench: clock, reset, point and configuration
// stimulus, result back-pressure and verdict. Depends on fbfs_pkg and fbfs_bend_checker.
`timescale 1ns / 1ps

module tb_top;
	import fbfs_pkg::*;

	localparam int DIMS           = DIMENSIONS_DEF;
	localparam int RANDOM_ITEMS   = 110;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 500;
	localparam logic [ADDR_W-1:0] RIGIDITY_ADDR = {REG_RIGIDITY, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               pt_valid, pt_stall;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic signed [31:0] force_x, force_y, force_z;
	logic               last_point;
	logic               res_valid, res_stall;
	logic signed [31:0] out_force_x, out_force_y, out_force_z;
	logic               saturated, last_result;
	int                 mismatch_count, pending;
	bit                 quiet;
	int                 idle_cycles;
	int                 sent;

	fiber_bending_force_stencil #(.DIMENSIONS(DIMS)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pt_valid(pt_valid), .pt_stall(pt_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.last_point(last_point),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
		.saturated(saturated), .last_result(last_result)
	);

	fbfs_bend_checker #(.DIMS(DIMS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.pt_valid(pt_valid), .pt_stall(pt_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.last_point(last_point),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
		.saturated(saturated), .last_result(last_result),
		.mismatch_count(mismatch_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		res_stall <= quiet ? 1'b0 : ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		if (!arst_n || (pt_valid && !pt_stall) || (res_valid && !res_stall)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(4))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'h0001_0000;
			3: return $urandom_range(32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_point(input logic [31:0] cx, cy, cz, fx, fy, fz, input logic last);
		while (!quiet && $urandom_range(99) < 38) begin
			pt_valid <= 1'b0;
			@(posedge clk);
		end
		pt_valid   <= 1'b1;
		coord_x    <= cx;
		coord_y    <= cy;
		coord_z    <= cz;
		force_x    <= fx;
		force_y    <= fy;
		force_z    <= fz;
		last_point <= last;
		@(posedge clk);
		while (pt_stall) @(posedge clk);
	endtask

	task automatic send_random_fiber(input int len);
		int k;
		for (k = 0; k < len; k++) begin
			send_point(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
				pick_value(), k == len - 1);
			sent = sent + 1;
		end
	endtask

	// Waits for every outstanding result, then lets the pipeline settle.
	task automatic drain();
		pt_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rigidity(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RIGIDITY_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		int phase, fibers, len, f;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		pt_valid   <= 1'b0;
		coord_x    <= '0;
		coord_y    <= '0;
		coord_z    <= '0;
		force_x    <= '0;
		force_y    <= '0;
		force_z    <= '0;
		last_point <= 1'b0;
		res_stall  <= 1'b0;
		quiet      <= 1'b0;
		sent       = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unit gain: short fibers of one and two points, then ordinary and clipping fibers.
		write_rigidity(32'h0001_0000);
		send_point(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 1'b1);
		send_point(32'h1, 32'h2, 32'h3, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
		send_point(32'h4, 32'h5, 32'h6, 32'h0000_0001, 32'h0, 32'hffff_0000, 1'b1);
		send_point(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
		send_point(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b0);
		send_point(32'h0004_0000, 32'hfffc_0000, 32'h0001_8000, 32'h5, 32'h6, 32'h7, 1'b1);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 1'b0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 1'b0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 1'b0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 1'b1);
		drain();

		// Largest gain: the products clip.
		write_rigidity(32'hffff_ffff);
		send_point(32'h0, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 1'b0);
		send_point(32'h0010_0000, 32'hfff0_0000, 32'h0000_0100, 32'h7fff_ffff,
			32'h8000_0000, 32'h0, 1'b0);
		send_point(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0);
		send_point(32'h0010_0000, 32'hfff0_0000, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 1'b0);
		send_point(32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0000_ffff, 32'h8000_0000, 1'b1);
		drain();

		// Zero gain: forces pass through unchanged.
		write_rigidity(32'h0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'h8000_0000,
			32'h0, 1'b0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'hffff_ffff, 1'b0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h0, 32'h1, 32'h7fff_ffff, 1'b1);
		drain();

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: write_rigidity(32'hffff_ffff);
				1: write_rigidity(32'h0);
				default: write_rigidity(pick_gain());
			endcase
			quiet  <= (phase == 3);
			fibers = (phase == 3) ? 5 : $urandom_range(2, 4);
			for (f = 0; f < fibers; f++) begin
				len = ($urandom_range(9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 9);
				send_random_fiber(len);
			end
			quiet <= 1'b0;
			drain();
			phase = phase + 1;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/fbfs_pkg.sv
rtl/core/fbfs_front.sv
rtl/core/fbfs_queue.sv
rtl/core/fbfs_back.sv
rtl/core/fiber_bending_force_stencil.sv
dv/fbfs_bend_checker.sv
dv/tb_top.sv
